[rtl/rsc_pkg.sv]
// shared constants, status codes and types for the slot cache
package rsc_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int TOP_BITS   = 5;
   localparam int COUNT_BITS = 16;
   localparam int TAG_BITS   = 32;
   localparam int CSR_BITS   = 5;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_ALLOC    = 3'd1;
   localparam logic [2:0] ST_NOFREE   = 3'd2;
   localparam logic [2:0] ST_DEC      = 3'd3;
   localparam logic [2:0] ST_FREED    = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;
   localparam logic [2:0] ST_SAT      = 3'd6;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic                is_put;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [SLOT_BITS-1:0]  slot;
      logic [COUNT_BITS-1:0] count;
   } rsp_type;

endpackage

[rtl/rsc_front.sv]
// request front end: two-word queue that classifies get and put requests
module rsc_front import rsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_func,
   input  logic [TAG_BITS-1:0] req_inode_number,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign take      = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ take;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff].is_put <= (req_func == FUNC_PUT);
         entry_ff[wr_ptr_ff].tag    <= req_inode_number;
      end
   end

endmodule

[rtl/rsc_back.sv]
// back end: tag lookup, count update, free stack and result queue
module rsc_back import rsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_wdata,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp
);

   typedef enum logic [1:0] {
      S_LOOK = 2'b01,
      S_UPD  = 2'b10
   } state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   state_type             state_ff, state_in;
   logic [TAG_BITS-1:0]   slot_tag_ff   [SLOTS];
   logic [COUNT_BITS-1:0] slot_count_ff [SLOTS];
   logic [SLOTS-1:0]      slot_busy_ff;
   logic [SLOT_BITS-1:0]  free_stack_ff [SLOTS];
   logic [TOP_BITS-1:0]   free_top_ff;

   // lookup results held for the update cycle
   logic                  hit_ff;
   logic [SLOT_BITS-1:0]  idx_ff;
   cmd_type               cmd_ff;

   logic [SLOTS-1:0]      match;
   logic                  hit;
   logic [SLOT_BITS-1:0]  idx;

   rsp_type               q_ff [2];
   logic                  q_wr_ff, q_rd_ff;
   logic [1:0]            q_count_ff;
   logic                  q_push;
   logic                  q_take;
   rsp_type               res;

   logic [COUNT_BITS-1:0] cur_count;
   logic [TOP_BITS-1:0]   top_minus1;
   logic [SLOT_BITS-1:0]  free_slot;
   logic [TOP_BITS-1:0]   init_top;

   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = slot_busy_ff[i] && (slot_tag_ff[i] == cmd.tag);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit = 1'b1;
            idx = SLOT_BITS'(i);
         end
      end
   end

   assign cmd_pop  = (state_ff == S_LOOK) && cmd_valid && (q_count_ff != 2'd2);
   assign q_push   = (state_ff == S_UPD);
   assign q_take   = rsp_pop && !rsp_empty;
   assign rsp_empty = (q_count_ff == 2'd0);
   assign rsp      = q_ff[q_rd_ff];

   assign cur_count  = slot_count_ff[idx_ff];
   assign top_minus1 = free_top_ff - TOP_BITS'(1);
   assign free_slot  = free_stack_ff[top_minus1[SLOT_BITS-1:0]];
   assign init_top  = (csr_wdata > CSR_BITS'(SLOTS)) ? TOP_BITS'(SLOTS) : TOP_BITS'(csr_wdata);

   always_comb begin
      res = '0;
      if (!cmd_ff.is_put) begin
         if (hit_ff) begin
            res.slot = idx_ff;
            if (cur_count == COUNT_MAX) begin
               res.status = ST_SAT;
               res.count  = cur_count;
            end else begin
               res.status = ST_HIT;
               res.count  = cur_count + COUNT_BITS'(1);
            end
         end else if (free_top_ff == '0) begin
            res.status = ST_NOFREE;
         end else begin
            res.status = ST_ALLOC;
            res.slot   = free_slot;
            res.count  = COUNT_BITS'(1);
         end
      end else begin
         if (!hit_ff) begin
            res.status = ST_NOTFOUND;
         end else if (cur_count > COUNT_BITS'(1)) begin
            res.status = ST_DEC;
            res.slot   = idx_ff;
            res.count  = cur_count - COUNT_BITS'(1);
         end else begin
            res.status = ST_FREED;
            res.slot   = idx_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOOK: begin
            if (cmd_pop) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_LOOK;
         end
         default: begin
            state_in = S_LOOK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOOK;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         hit_ff <= hit;
         idx_ff <= idx;
         cmd_ff <= cmd;
      end
   end

   // slot state: reset and csr writes re-seed the free stack
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         slot_busy_ff <= '0;
         free_top_ff  <= reset ? TOP_BITS'(SLOTS) : init_top;
         for (int i = 0; i < SLOTS; i++) begin
            free_stack_ff[i] <= SLOT_BITS'(i);
         end
      end else if (state_ff == S_UPD) begin
         unique case (res.status) inside
            ST_HIT, ST_DEC: begin
               slot_count_ff[idx_ff] <= res.count;
            end
            ST_ALLOC: begin
               slot_busy_ff[free_slot]  <= 1'b1;
               slot_tag_ff[free_slot]   <= cmd_ff.tag;
               slot_count_ff[free_slot] <= COUNT_BITS'(1);
               free_top_ff              <= free_top_ff - TOP_BITS'(1);
            end
            ST_FREED: begin
               slot_busy_ff[idx_ff]  <= 1'b0;
               slot_tag_ff[idx_ff]   <= '0;
               slot_count_ff[idx_ff] <= '0;
               if (free_top_ff < TOP_BITS'(SLOTS)) begin
                  free_stack_ff[free_top_ff[SLOT_BITS-1:0]] <= idx_ff;
                  free_top_ff <= free_top_ff + TOP_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result queue, two words
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= 1'b0;
         q_rd_ff    <= 1'b0;
         q_count_ff <= 2'd0;
      end else begin
         q_wr_ff    <= q_wr_ff ^ q_push;
         q_rd_ff    <= q_rd_ff ^ q_take;
         q_count_ff <= q_count_ff + {1'b0, q_push} - {1'b0, q_take};
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff] <= res;
      end
   end

endmodule

[rtl/refcounted_slot_cache.sv]
// top level of the reference-counted inode slot cache
// a request word passes the front queue, then the lookup and update states
// the back end takes no new word until its lookup then update pass is done
// both sides buffer two words; a stalled result side stops requests once both fill
// reset (synchronous, active high) empties both queues and frees all 16 slots
module refcounted_slot_cache import rsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_func,
   input  logic [TAG_BITS-1:0]   req_inode_number,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_status,
   output logic [SLOT_BITS-1:0]  rsp_slot_index,
   output logic [COUNT_BITS-1:0] rsp_ref_count,
   input  logic                  csr_we,
   input  logic [CSR_BITS-1:0]   csr_wdata
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   rsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_inode_number (req_inode_number),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   rsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_slot_index = rsp.slot;
   assign rsp_ref_count  = rsp.count;

endmodule
